FILE: rtl/ir_pulse_word_deframer_top_defines.svh
`ifndef IR_PULSE_WORD_DEFRAMER_TOP_DEFINES_SVH
`define IR_PULSE_WORD_DEFRAMER_TOP_DEFINES_SVH

// Check on every clock edge, masked while reset is asserted.
`define IPWD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define IPWD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/ipwd_pkg.sv
`timescale 1ns / 1ps

package ipwd_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned DUR_W       = 15;
  localparam int unsigned SCALE_W     = 16;
  localparam int unsigned PROD_W      = DUR_W + SCALE_W;
  localparam int unsigned QUO_W       = 16;
  localparam int unsigned KIND_BIT    = 7;

  localparam int unsigned SCALE_DIV   = 15625;
  // Scaling by 256 folds into the shift: q = (x * 2^40 / 15625) >> 32.
  localparam int unsigned RECIP_EXP   = 40;
  localparam int unsigned RECIP_SHIFT = 32;
  localparam int unsigned RECIP_W     = 27;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((64'd1 << RECIP_EXP) / 64'(SCALE_DIV));
  localparam int unsigned QPROD_W     = PROD_W + RECIP_W;
  // low product bits that survive the x256 shift inside a 15-bit remainder
  localparam int unsigned XLO_W       = DUR_W + RECIP_SHIFT - RECIP_EXP;

  localparam logic [DUR_W-1:0] DUR_MAX = {DUR_W{1'b1}};

  typedef struct packed {
    logic             is_pulse;
    logic [DUR_W-1:0] duration;
    logic             realigned;
  } word_t;

  typedef struct packed {
    word_t             word;
    logic              scale_zero;
    logic [PROD_W-1:0] prod;
  } stage_a_t;

endpackage

FILE: rtl/ipwd_byte_if.sv
`timescale 1ns / 1ps

interface ipwd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: rtl/ipwd_word_if.sv
`timescale 1ns / 1ps

interface ipwd_word_if;
  logic        valid;
  logic        ready;
  logic        is_pulse;
  logic [14:0] duration;
  logic        realigned;

  modport source (output valid, output is_pulse, output duration, output realigned,
                  input ready);
  modport sink (input valid, input is_pulse, input duration, input realigned,
                output ready);
endinterface

FILE: rtl/ipwd_deframer.sv
`timescale 1ns / 1ps
`include "ir_pulse_word_deframer_top_defines.svh"

module ipwd_deframer (
  input  logic                           clk,
  input  logic                           rst_n,
  ipwd_byte_if.sink                      in_if,
  input  logic [ipwd_pkg::SCALE_W-1:0]   tick_scale,
  output logic                           a_valid,
  output ipwd_pkg::stage_a_t             a_data,
  input  logic                           a_ready
);

  logic [ipwd_pkg::BYTE_W-1:0] held_r, held_nxt;
  logic                        low_r, low_nxt;
  logic                        slip_r, slip_nxt;
  logic                        known_r, known_nxt;
  logic                        last_r, last_nxt;
  logic                        a_v_r, a_v_nxt;
  ipwd_pkg::stage_a_t          a_r, a_nxt;

  logic accept;
  logic kind;
  logic repeat_kind;
  logic emit;
  logic [ipwd_pkg::DUR_W-1:0] dur;

  assign in_if.ready = !a_v_r || a_ready;
  assign accept      = in_if.valid && in_if.ready;
  assign kind        = in_if.rx_byte[ipwd_pkg::KIND_BIT];
  assign repeat_kind = !slip_r && known_r && (kind == last_r);
  assign emit        = accept && low_r && !repeat_kind;
  assign dur         = {in_if.rx_byte[ipwd_pkg::KIND_BIT-1:0], held_r};

  always_comb begin
    held_nxt  = held_r;
    low_nxt   = low_r;
    slip_nxt  = slip_r;
    known_nxt = known_r;
    last_nxt  = last_r;
    if (accept) begin
      priority if (!low_r) begin
        held_nxt = in_if.rx_byte;
        low_nxt  = 1'b1;
      end else if (repeat_kind) begin
        // slip one byte: the high byte becomes the next low byte
        held_nxt = in_if.rx_byte;
        slip_nxt = 1'b1;
      end else begin
        low_nxt   = 1'b0;
        slip_nxt  = 1'b0;
        known_nxt = 1'b1;
        last_nxt  = kind;
      end
    end
  end

  always_comb begin
    a_nxt.word.is_pulse  = kind;
    a_nxt.word.duration  = dur;
    a_nxt.word.realigned = slip_r;
    a_nxt.scale_zero     = (tick_scale == '0);
    a_nxt.prod           = ipwd_pkg::PROD_W'(dur) * ipwd_pkg::PROD_W'(tick_scale);
    a_v_nxt              = emit || (a_v_r && !a_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= '0;
      low_r   <= 1'b0;
      slip_r  <= 1'b0;
      known_r <= 1'b0;
      last_r  <= 1'b0;
      a_v_r   <= 1'b0;
    end else begin
      held_r  <= held_nxt;
      low_r   <= low_nxt;
      slip_r  <= slip_nxt;
      known_r <= known_nxt;
      last_r  <= last_nxt;
      a_v_r   <= a_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      a_r <= a_nxt;
    end
  end

  assign a_valid = a_v_r;
  assign a_data  = a_r;

  `IPWD_ASSERT_ALWAYS(a_slip_needs_low, (!rst_n || !slip_r || low_r),
    "slip pending without a held low byte")
  `IPWD_ASSERT(a_slip_word_marked, (accept && low_r && slip_r |=> a_v_r && a_r.word.realigned),
    "word after a slip not marked realigned")
  `IPWD_ASSERT(a_word_sets_kind, (a_v_r |-> known_r),
    "word issued while last kind still unknown")

endmodule

FILE: rtl/ipwd_scaler.sv
`timescale 1ns / 1ps
`include "ir_pulse_word_deframer_top_defines.svh"

module ipwd_scaler (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               a_valid,
  input  ipwd_pkg::stage_a_t a_data,
  output logic               a_ready,
  ipwd_word_if.source        out_if
);

  logic                              b_v_r, b_v_nxt;
  ipwd_pkg::word_t                   b_word_r;
  logic                              b_zero_r;
  logic [ipwd_pkg::XLO_W-1:0]        b_xlo_r;
  logic [ipwd_pkg::QUO_W-1:0]        b_q0_r;

  logic                              o_v_r, o_v_nxt;
  ipwd_pkg::word_t                   o_word_r, o_word_nxt;

  logic                              o_ready;
  logic                              b_ready;
  logic                              b_load;
  logic                              o_load;
  logic [ipwd_pkg::QPROD_W-1:0]      qprod;
  logic [2*ipwd_pkg::DUR_W-1:0]      qmul;
  logic [ipwd_pkg::DUR_W-1:0]        rem;
  logic                              inc;
  logic [ipwd_pkg::QUO_W-1:0]        quo;
  logic [ipwd_pkg::DUR_W-1:0]        sat;

  assign o_ready = !o_v_r || out_if.ready;
  assign b_ready = !b_v_r || o_ready;
  assign a_ready = b_ready;
  assign b_load  = a_valid && b_ready;
  assign o_load  = b_v_r && o_ready;

  // quotient estimate, low by at most one
  assign qprod = ipwd_pkg::QPROD_W'(a_data.prod) * ipwd_pkg::QPROD_W'(ipwd_pkg::RECIP);

  // the true remainder stays below twice the divisor, so its low bits suffice
  always_comb begin
    qmul = (2*ipwd_pkg::DUR_W)'(b_q0_r[ipwd_pkg::DUR_W-1:0]) *
           (2*ipwd_pkg::DUR_W)'(ipwd_pkg::SCALE_DIV);
    rem  = {b_xlo_r, {ipwd_pkg::BYTE_W{1'b0}}} - qmul[ipwd_pkg::DUR_W-1:0];
    inc  = (rem >= ipwd_pkg::DUR_W'(ipwd_pkg::SCALE_DIV));
    quo  = b_q0_r + ipwd_pkg::QUO_W'(inc);
    sat  = (quo >= ipwd_pkg::QUO_W'(ipwd_pkg::DUR_MAX)) ? ipwd_pkg::DUR_MAX
                                                       : quo[ipwd_pkg::DUR_W-1:0];
    o_word_nxt          = b_word_r;
    o_word_nxt.duration = b_zero_r ? b_word_r.duration : sat;
    b_v_nxt             = b_load || (b_v_r && !o_ready);
    o_v_nxt             = o_load || (o_v_r && !out_if.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      b_v_r <= b_v_nxt;
      o_v_r <= o_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      b_word_r <= a_data.word;
      b_zero_r <= a_data.scale_zero;
      b_xlo_r  <= a_data.prod[ipwd_pkg::XLO_W-1:0];
      b_q0_r   <= qprod[ipwd_pkg::RECIP_SHIFT +: ipwd_pkg::QUO_W];
    end
    if (o_load) begin
      o_word_r <= o_word_nxt;
    end
  end

  assign out_if.valid     = o_v_r;
  assign out_if.is_pulse  = o_word_r.is_pulse;
  assign out_if.duration  = o_word_r.duration;
  assign out_if.realigned = o_word_r.realigned;

  `IPWD_ASSERT(s_rem_bound, (b_v_r && !b_zero_r |-> rem < ipwd_pkg::DUR_W'(2*ipwd_pkg::SCALE_DIV)),
    "quotient estimate off by more than one")
  `IPWD_ASSERT(s_stage_b_fills, (a_valid && b_ready |=> b_v_r),
    "stage request dropped between multiplies")
  `IPWD_ASSERT(s_out_holds, (o_v_r && !out_if.ready |=> o_v_r),
    "stalled result dropped")

endmodule

FILE: rtl/ir_pulse_word_deframer_top.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake        Payload
// in_if     in   valid / ready    rx_byte[7:0]
// out_if    out  valid / ready    is_pulse, duration[14:0], realigned
// cfg       in   cfg_we           cfg_wdata[15:0] -> tick_scale
//
// One byte is taken per cycle while in_if.ready is high; a completed word passes
// through three registered stages (pairing plus first multiply, reciprocal multiply,
// remainder correction and saturation) before it is offered on out_if.
// rst_n is synchronous and active low; it clears the pairing state and tick_scale.
// A stall on out_if fills the three stages before in_if.ready falls.

module ir_pulse_word_deframer_top (
  input  logic        clk,
  input  logic        rst_n,
  ipwd_byte_if.sink   in_if,
  ipwd_word_if.source out_if,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic [ipwd_pkg::SCALE_W-1:0] tick_scale_r, tick_scale_nxt;
  logic                         a_valid;
  ipwd_pkg::stage_a_t           a_data;
  logic                         a_ready;

  assign tick_scale_nxt = cfg_we ? cfg_wdata : tick_scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_scale_r <= '0;
    end else begin
      tick_scale_r <= tick_scale_nxt;
    end
  end

  ipwd_deframer u_deframer (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .tick_scale (tick_scale_r),
    .a_valid    (a_valid),
    .a_data     (a_data),
    .a_ready    (a_ready)
  );

  ipwd_scaler u_scaler (
    .clk     (clk),
    .rst_n   (rst_n),
    .a_valid (a_valid),
    .a_data  (a_data),
    .a_ready (a_ready),
    .out_if  (out_if)
  );

endmodule

FILE: bench/ipwd_deframe_check.sv
`timescale 1ns / 1ps

module ipwd_deframe_check (
  input  logic        clk,
  input  logic        rst_n,
  ipwd_byte_if        byte_ch,
  ipwd_word_if        word_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output int          mismatches,
  output int          words_pending,
  output int          words_seen,
  output int          slips_seen
);

  localparam int unsigned TICK_MUL   = 256;

  logic [ipwd_pkg::BYTE_W-1:0]  low_byte;
  logic                         have_low;
  logic                         kind_known;
  logic                         prev_kind;
  logic                         slip_armed;
  logic [ipwd_pkg::SCALE_W-1:0] tick_scale;
  ipwd_pkg::word_t              word_q[$];
  int                           bad_cnt;
  int                           seen_cnt;
  int                           slip_cnt;

  function automatic logic [ipwd_pkg::DUR_W-1:0] rescale(
    input logic [ipwd_pkg::DUR_W-1:0]   d,
    input logic [ipwd_pkg::SCALE_W-1:0] s);
    logic [63:0] prod;
    logic [15:0] quo;
    if (s == '0) return d;
    prod = 64'(d) * 64'(s) * 64'(TICK_MUL);
    quo  = 16'(prod / 64'(ipwd_pkg::SCALE_DIV));
    return (quo < 16'(ipwd_pkg::DUR_MAX)) ? quo[ipwd_pkg::DUR_W-1:0] : ipwd_pkg::DUR_MAX;
  endfunction

  // Pair one accepted byte; queue the word it completes, if any.
  function automatic void pair_byte(input logic [ipwd_pkg::BYTE_W-1:0] b);
    logic            kind;
    ipwd_pkg::word_t w;
    if (!have_low) begin
      low_byte = b;
      have_low = 1'b1;
      return;
    end
    kind = b[ipwd_pkg::KIND_BIT];
    if (!slip_armed && kind_known && kind == prev_kind) begin
      // same kind twice: slip one byte and keep this one as the low byte
      low_byte   = b;
      slip_armed = 1'b1;
      return;
    end
    w.is_pulse  = kind;
    w.duration  = rescale({b[6:0], low_byte}, tick_scale);
    w.realigned = slip_armed;
    have_low    = 1'b0;
    slip_armed  = 1'b0;
    kind_known  = 1'b1;
    prev_kind   = kind;
    word_q.push_back(w);
  endfunction

  task automatic report(input string field, input int want, input int got);
    bad_cnt++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    ipwd_pkg::word_t want;
    if (!rst_n) begin
      low_byte   = '0;
      have_low   = 1'b0;
      kind_known = 1'b0;
      prev_kind  = 1'b0;
      slip_armed = 1'b0;
      tick_scale = '0;
      word_q.delete();
      bad_cnt    = 0;
      seen_cnt   = 0;
      slip_cnt   = 0;
    end else begin
      if (word_ch.valid && word_ch.ready) begin
        if (word_q.size() == 0) begin
          bad_cnt++;
          $display("%0t: word mismatch, expected none, actual pulse=%0d dur=%0h slip=%0d",
                   $time, word_ch.is_pulse, word_ch.duration, word_ch.realigned);
        end else begin
          want = word_q.pop_front();
          seen_cnt++;
          if (word_ch.realigned) slip_cnt++;
          if (word_ch.is_pulse !== want.is_pulse)
            report("is_pulse", want.is_pulse, word_ch.is_pulse);
          if (word_ch.duration !== want.duration)
            report("duration", want.duration, word_ch.duration);
          if (word_ch.realigned !== want.realigned)
            report("realigned", want.realigned, word_ch.realigned);
        end
      end
      if (cfg_we) tick_scale = cfg_wdata;
      if (byte_ch.valid && byte_ch.ready) pair_byte(byte_ch.rx_byte);
    end
    mismatches    <= bad_cnt;
    words_pending <= word_q.size();
    words_seen    <= seen_cnt;
    slips_seen    <= slip_cnt;
  end

endmodule

FILE: bench/ir_pulse_word_deframer_top_tb.sv
`timescale 1ns / 1ps

module ir_pulse_word_deframer_top_tb;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE       = 8;
  localparam int PHASE_BYTES  = 125;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  bit          calm = 1'b0;
  int          gap_pct = 15;
  logic        stream_kind = 1'b0;
  int          cycles = 0;
  int          bytes_sent = 0;
  int          scale_writes = 0;
  int          mismatches;
  int          words_pending;
  int          words_seen;
  int          slips_seen;

  ipwd_byte_if byte_ch ();
  ipwd_word_if word_ch ();

  ir_pulse_word_deframer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (byte_ch),
    .out_if    (word_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  ipwd_deframe_check word_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .byte_ch       (byte_ch),
    .word_ch       (word_ch),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .mismatches    (mismatches),
    .words_pending (words_pending),
    .words_seen    (words_seen),
    .slips_seen    (slips_seen)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("ir_pulse_word_deframer_top_tb NOT OK");
      $finish;
    end
  end

  // Result side: stall in bursts, with long runs of steady ready.
  initial begin
    int n;
    word_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (calm) begin
        word_ch.ready <= 1'b1;
        n = 1;
      end else if ($urandom_range(0, 7) == 0) begin
        word_ch.ready <= 1'b1;
        n = $urandom_range(100, 300);
      end else if ($urandom_range(0, 2) != 0) begin
        word_ch.ready <= 1'b1;
        n = $urandom_range(1, 40);
      end else begin
        word_ch.ready <= 1'b0;
        n = $urandom_range(1, 16);
      end
      repeat (n) @(posedge clk);
    end
  end

  // Call only at a rising edge; returns at the edge that accepts the byte.
  task automatic put_byte(input logic [7:0] b);
    if (!calm && $urandom_range(1, 100) <= gap_pct) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.rx_byte <= b;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic put_word(input logic kind, input logic [14:0] d);
    put_byte(d[7:0]);
    put_byte({kind, d[14:8]});
  endtask

  // Hold off until every expected word has drained and the pipe is empty.
  task automatic settle();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_scale(input logic [15:0] s);
    cfg_we    <= 1'b1;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_we    <= 1'b0;
    scale_writes++;
  endtask

  // Mostly alternating pulse/space words; some repeats, stray bytes and junk.
  task automatic run_traffic(input int count);
    int          start;
    int          r;
    logic [14:0] d;
    start = bytes_sent;
    while (bytes_sent - start < count) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 3) == 0) d = 15'($urandom_range(0, 255));
      else d = 15'($urandom());
      if (r < 78) begin
        stream_kind = ~stream_kind;
        put_word(stream_kind, d);
      end else if (r < 88) begin
        put_word(stream_kind, d);
      end else if (r < 95) begin
        put_byte(8'($urandom()));
      end else begin
        put_word(1'($urandom_range(0, 1)), d);
      end
    end
  endtask

  initial begin
    logic [15:0] phase_scale [7];
    byte_ch.valid   = 1'b0;
    byte_ch.rx_byte = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // pass-through: first word of unknown kind, extremes, slips
    put_word(1'b0, 15'h0000);
    put_word(1'b1, 15'h7fff);
    put_byte(8'h12);
    put_byte(8'h85);
    put_byte(8'h00);
    put_byte(8'h34);
    put_byte(8'h12);
    put_byte(8'h05);
    settle();

    // full scale: wrap past 16 bits, saturation, zero
    set_scale(16'hffff);
    put_word(1'b1, 15'h7fff);
    put_word(1'b0, 15'd40);
    put_word(1'b1, 15'h0001);
    put_word(1'b0, 15'h0000);
    settle();

    set_scale(16'h0001);
    put_word(1'b1, 15'h7fff);
    put_word(1'b0, 15'd60);
    settle();

    phase_scale[0] = 16'h0000;
    phase_scale[1] = 16'd62;
    phase_scale[2] = 16'hffff;
    phase_scale[3] = 16'($urandom());
    phase_scale[4] = 16'($urandom_range(1, 200));
    phase_scale[5] = 16'h0001;
    phase_scale[6] = 16'($urandom());
    foreach (phase_scale[i]) begin
      set_scale(phase_scale[i]);
      gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      if (i == 6) calm = 1'b1;
      run_traffic(PHASE_BYTES);
      settle();
    end

    $display("Sent %0d bytes under %0d tick_scale writes (0, 1, 0xffff and others);",
             bytes_sent, scale_writes);
    $display("checked %0d words, %0d of them completed after a byte slip.",
             words_seen, slips_seen);
    if (mismatches == 0)
      $display("ir_pulse_word_deframer_top_tb OK");
    else
      $display("ir_pulse_word_deframer_top_tb NOT OK");
    $finish;
  end

endmodule
